[rtl/apc_pkg.sv]
// shared types, constants and tables for the peak compressor
package apc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int SW = SAMPLE_BITS;

    localparam logic [2:0] REG_THR = 3'd0;
    localparam logic [2:0] REG_RATIO = 3'd1;
    localparam logic [2:0] REG_ATK = 3'd2;
    localparam logic [2:0] REG_REL = 3'd3;
    localparam logic [2:0] REG_MAKEUP = 3'd4;
    localparam logic [2:0] REG_DRYWET = 3'd5;

    // datapath operation selected by the sequencer
    typedef enum logic [4:0] {
        OP_GLIDE = 5'd0,   // threshold and ratio glide
        OP_ENV   = 5'd1,   // envelope update
        OP_LOGN  = 5'd2,   // log2 normalize
        OP_LSQ   = 5'd3,   // one squaring step of log2
        OP_DB    = 5'd4,   // log2 to dB, compare threshold
        OP_SLDIV = 5'd5,   // one slope quotient bit
        OP_RED   = 5'd6,   // dB reduction
        OP_EXPN  = 5'd7,   // exponent, split n and f
        OP_EXPM  = 5'd8,   // one exp2 table multiply
        OP_GAIN  = 5'd9,   // shift, glide gain
        OP_WET1  = 5'd10,  // x times gain
        OP_WET2  = 5'd11,  // times makeup
        OP_MIX   = 5'd12   // dry/wet mix, saturate
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
        logic [3:0] step;
    } t_cmd;

    typedef struct packed {
        logic unity;   // target gain is 1.0, skip
    } t_stat;

    function automatic logic [31:0] exp2_tab(input logic [3:0] i);
        logic [31:0] v;
        case (i)
            4'd0: v = 32'd1518500250;
            4'd1: v = 32'd1276901417;
            4'd2: v = 32'd1170923762;
            4'd3: v = 32'd1121280435;
            4'd4: v = 32'd1097253708;
            4'd5: v = 32'd1085434106;
            4'd6: v = 32'd1079572136;
            4'd7: v = 32'd1076653033;
            4'd8: v = 32'd1075196443;
            4'd9: v = 32'd1074468887;
            4'd10: v = 32'd1074105294;
            4'd11: v = 32'd1073923544;
            default: v = 32'd1073741824;
        endcase
        return v;
    endfunction

    // round to nearest, ties away from zero, arithmetic shift by s
    function automatic logic signed [63:0] rsh(input logic signed [63:0] v,
                                               input int s);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

endpackage

[rtl/apc_ctrl.sv]
// sequencer for the compressor datapath
module apc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic                i_buffer_start,
    input  apc_pkg::t_stat      i_stat,
    output apc_pkg::t_cmd       o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PRE  = 7'b0000010,
        S_LOG  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_EXP  = 7'b0010000,
        S_POST = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic r_bs, n_bs;

    // output stage is a register; a new beat is taken once the old one is gone
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt + 5'd1;
        n_bs = r_bs;
        o_cmd.start = 1'b0;
        o_cmd.op = apc_pkg::OP_ENV;
        o_cmd.step = r_cnt[3:0];
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                // idle command leaves all datapath state untouched but the sample, which start loads
                o_cmd.op = apc_pkg::OP_MIX;
                o_cmd.step = '1;
                o_cmd.start = i_in_valid;
                if (i_in_valid) begin
                    n_bs = i_buffer_start;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                // cnt 0 glide on buffer start (else env, then skip to 2), 1 env, 2 log normalize
                case (r_cnt)
                    5'd0: o_cmd.op = r_bs ? apc_pkg::OP_GLIDE : apc_pkg::OP_ENV;
                    5'd1: o_cmd.op = apc_pkg::OP_ENV;
                    default: o_cmd.op = apc_pkg::OP_LOGN;
                endcase
                if (r_cnt == 5'd0 && !r_bs) n_cnt = 5'd2;
                if (r_cnt == 5'd2) begin
                    n_cnt = '0;
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                o_cmd.op = (r_cnt == 5'd16) ? apc_pkg::OP_DB : apc_pkg::OP_LSQ;
                if (r_cnt == 5'd16) begin
                    n_cnt = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = (r_cnt == 5'd17) ? apc_pkg::OP_EXPN :
                           (r_cnt == 5'd16) ? apc_pkg::OP_RED : apc_pkg::OP_SLDIV;
                if (r_cnt == 5'd0 && i_stat.unity) begin
                    o_cmd.op = apc_pkg::OP_GAIN;
                    n_cnt = 5'd1;
                    n_state = S_POST;
                end else if (r_cnt == 5'd17) begin
                    n_cnt = '0;
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                o_cmd.op = apc_pkg::OP_EXPM;
                if (r_cnt == 5'd11) begin
                    n_cnt = '0;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                case (r_cnt)
                    5'd0: o_cmd.op = apc_pkg::OP_GAIN;
                    5'd1: o_cmd.op = apc_pkg::OP_WET1;
                    5'd2: o_cmd.op = apc_pkg::OP_WET2;
                    default: o_cmd.op = apc_pkg::OP_MIX;
                endcase
                if (r_cnt == 5'd3) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.op = apc_pkg::OP_MIX;
                o_cmd.step = '1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_bs <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_bs <= n_bs;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while result held");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready) else $error("second beat taken");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
endmodule

[rtl/apc_dp.sv]
// compressor datapath: state, per-operation multipliers, log/exp steps
module apc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  apc_pkg::t_cmd                 i_cmd,
    output apc_pkg::t_stat                o_stat,
    input  logic signed [apc_pkg::SW-1:0] i_sample,
    input  logic [13:0]                   i_thr,
    input  logic [12:0]                   i_ratio,
    input  logic [15:0]                   i_atk,
    input  logic [15:0]                   i_rel,
    input  logic [15:0]                   i_makeup,
    input  logic [16:0]                   i_dw,
    output logic signed [apc_pkg::SW-1:0] o_sample
);
    localparam int SW = apc_pkg::SW;

    logic signed [SW-1:0] r_x;
    logic [SW-1:0] r_env, n_env;
    logic [31:0] r_gain, n_gain;
    logic signed [23:0] r_sthr, n_sthr;
    logic [23:0] r_sratio, n_sratio;
    logic [31:0] r_m, n_m;           // log mantissa, then exp product
    logic signed [7:0] r_lp, n_lp;   // log integer part
    logic [15:0] r_frac, n_frac;
    logic signed [31:0] r_over, n_over;
    logic [16:0] r_q, n_q;           // slope quotient
    logic [40:0] r_rem, n_rem;
    logic [11:0] r_g, n_g;
    logic [5:0] r_n, n_n;
    logic r_zero, n_zero;            // target gain 0
    logic r_unity, n_unity;
    logic signed [47:0] r_acc, n_acc;
    logic signed [SW-1:0] r_out, n_out;

    logic [SW-1:0] ax;
    logic [15:0] c;
    logic [63:0] sq;
    logic [31:0] tg;
    logic signed [63:0] t64;
    logic [5:0] p;
    logic [40:0] dsub;
    logic [16:0] dwc;
    logic signed [63:0] lim;

    assign o_stat.unity = r_unity;
    assign o_sample = r_out;

    always_comb begin
        ax = r_x[SW-1] ? SW'(-r_x) : SW'(r_x);
        c = (ax > r_env) ? i_atk : i_rel;
        sq = 64'(r_m) * 64'(r_m);
        tg = r_zero ? 32'd0 : (r_unity ? 32'h8000_0000 : (r_m >> r_n));
        dwc = (i_dw > 17'd65536) ? 17'd65536 : i_dw;
        dsub = {r_rem[39:0], 1'b0} - {17'd0, r_sratio};
        lim = 64'sd1 <<< (SW - 1);
        p = '0;
        for (int k = 0; k < SW; k++) if (r_env[k]) p = 6'(k);
        t64 = '0;

        n_env = r_env; n_gain = r_gain; n_sthr = r_sthr; n_sratio = r_sratio;
        n_m = r_m; n_lp = r_lp; n_frac = r_frac; n_over = r_over;
        n_q = r_q; n_rem = r_rem; n_g = r_g; n_n = r_n; n_zero = r_zero;
        n_unity = r_unity; n_acc = r_acc; n_out = r_out;

        if (!i_cmd.start) begin
            case (i_cmd.op)
                apc_pkg::OP_GLIDE: begin
                    n_sthr = 24'(r_sthr + apc_pkg::rsh(
                        (64'($signed(i_thr)) * 256 - 64'(r_sthr)) * 1049, 20));
                    n_sratio = 24'(64'(r_sratio) + apc_pkg::rsh(
                        (64'(i_ratio) * 256 - 64'(r_sratio)) * 1049, 20));
                end
                apc_pkg::OP_ENV: begin
                    if (i_cmd.step == 4'd0 || i_cmd.step == 4'd1)
                        n_env = SW'((64'(c) * 64'(r_env) + 64'(17'd65536 - 17'(c)) * 64'(ax)
                                     + 64'd32768) >> 16);
                end
                apc_pkg::OP_LOGN: begin
                    n_m = 32'(64'(r_env) << (30 - p));
                    n_lp = 8'($signed({2'b0, p}) - 8'(SW - 1));
                    n_frac = '0;
                    n_unity = (r_env == '0);
                    n_zero = 1'b0;
                end
                apc_pkg::OP_LSQ: begin
                    t64 = 64'(sq >> 30);
                    if (t64[31]) begin
                        n_m = 32'(t64 >> 1);
                        n_frac = {r_frac[14:0], 1'b1};
                    end else begin
                        n_m = t64[31:0];
                        n_frac = {r_frac[14:0], 1'b0};
                    end
                end
                apc_pkg::OP_DB: begin
                    t64 = apc_pkg::rsh((64'(r_lp) * 65536 + 64'(r_frac)) * 394566, 16);
                    n_over = 32'(t64 - 64'(r_sthr));
                    if (r_unity || t64 <= 64'(r_sthr) || r_sratio <= 24'd65536)
                        n_unity = 1'b1;
                    n_rem = 41'(r_sratio - 24'd65536);
                    n_q = '0;
                end
                apc_pkg::OP_SLDIV: begin
                    // restoring division of (r-1)<<16 by r, one bit a step
                    if (!dsub[40]) begin
                        n_rem = dsub;
                        n_q = {r_q[15:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[39:0], 1'b0};
                        n_q = {r_q[15:0], 1'b0};
                    end
                end
                apc_pkg::OP_RED: begin
                    n_acc = 48'((64'(r_over) * 64'(r_q) + (64'd1 << 23)) >>> 24);
                end
                apc_pkg::OP_EXPN: begin
                    t64 = (64'(r_acc) * 64'd174165 + 64'd32768) >>> 16;
                    n_n = (t64[63:12] >= 64'd32) ? 6'd32 : t64[17:12];
                    n_zero = (t64[63:12] >= 64'd32);
                    n_g = 12'(13'd4096 - 13'(t64[11:0]));
                    n_m = 32'h4000_0000;
                    if (t64[11:0] == 12'd0) begin
                        n_g = '0;
                        n_m = 32'h8000_0000;
                    end
                end
                apc_pkg::OP_EXPM: begin
                    if (r_g[11 - i_cmd.step])
                        n_m = 32'((64'(r_m) * 64'(apc_pkg::exp2_tab(i_cmd.step))
                                   + (64'd1 << 29)) >> 30);
                end
                apc_pkg::OP_GAIN: begin
                    n_gain = 32'($signed({32'd0, r_gain}) + apc_pkg::rsh(
                        ($signed({32'd0, tg}) - $signed({32'd0, r_gain})) * 105, 20));
                end
                apc_pkg::OP_WET1: begin
                    n_acc = 48'(apc_pkg::rsh(64'(r_x) * $signed({32'd0, r_gain}), 31));
                end
                apc_pkg::OP_WET2: begin
                    n_acc = 48'(apc_pkg::rsh(64'(r_acc) * 64'(i_makeup), 12));
                end
                apc_pkg::OP_MIX: begin
                    if (i_cmd.step != 4'hf) begin
                        t64 = apc_pkg::rsh(64'(r_x) * 64'(17'd65536 - dwc)
                                           + 64'(r_acc) * 64'(dwc), 16);
                        if (t64 > lim - 1) n_out = SW'(lim - 1);
                        else if (t64 < -lim) n_out = SW'(-lim);
                        else n_out = SW'(t64);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= '0;
            r_gain <= 32'h8000_0000;
            r_sthr <= '0;
            r_sratio <= 24'd65536;
            r_unity <= 1'b0;
        end else begin
            r_env <= n_env;
            r_gain <= n_gain;
            r_sthr <= n_sthr;
            r_sratio <= n_sratio;
            r_unity <= n_unity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) r_x <= i_sample;
        r_m <= n_m; r_lp <= n_lp; r_frac <= n_frac; r_over <= n_over;
        r_q <= n_q; r_rem <= n_rem; r_g <= n_g; r_n <= n_n; r_zero <= n_zero;
        r_acc <= n_acc; r_out <= n_out;
    end

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= 32'h8000_0000) else $error("gain above unity");
    a_red_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == apc_pkg::OP_RED && !i_cmd.start) |-> (!r_unity && r_over > 0))
        else $error("reduction below threshold");
    a_zero_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == apc_pkg::OP_EXPN && !i_cmd.start) |=> (r_zero == (r_n == 6'd32)))
        else $error("exponent split mismatch");
endmodule

[rtl/audio_peak_compressor.sv]
// Peak compressor top level: APB registers, sequencer and datapath.
// One sample per beat, 24-bit signed. After acceptance a sample passes
// through 16 log2 squaring steps on a multiplier and 16 slope quotient
// bits on a divider step, then 12 exp2 table multiplies; below threshold
// the tail is skipped. A new beat is taken once the result has been
// taken. Registers: 0 threshold, 1 ratio, 2 attack, 3 release,
// 4 makeup, 5 dry/wet, at byte offsets 4*i.
module audio_peak_compressor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [apc_pkg::SW-1:0] i_sample_in,
    input  logic                          i_buffer_start,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [apc_pkg::SW-1:0] o_sample_out
);
    logic [13:0] r_thr;
    logic [12:0] r_ratio;
    logic [15:0] r_atk, r_rel, r_makeup;
    logic [16:0] r_dw;
    logic [2:0] idx;
    apc_pkg::t_cmd cmd;
    apc_pkg::t_stat stat;

    assign pready = 1'b1;
    assign idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 14'h3400;
            r_ratio <= 13'd1024;
            r_atk <= 16'd65387;
            r_rel <= 16'd65521;
            r_makeup <= 16'd8173;
            r_dw <= 17'd65536;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (idx)
                apc_pkg::REG_THR: r_thr <= pwdata[13:0];
                apc_pkg::REG_RATIO: r_ratio <= pwdata[12:0];
                apc_pkg::REG_ATK: r_atk <= pwdata[15:0];
                apc_pkg::REG_REL: r_rel <= pwdata[15:0];
                apc_pkg::REG_MAKEUP: r_makeup <= pwdata[15:0];
                apc_pkg::REG_DRYWET: r_dw <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            apc_pkg::REG_THR: prdata = {{18{r_thr[13]}}, r_thr};
            apc_pkg::REG_RATIO: prdata = {19'd0, r_ratio};
            apc_pkg::REG_ATK: prdata = {16'd0, r_atk};
            apc_pkg::REG_REL: prdata = {16'd0, r_rel};
            apc_pkg::REG_MAKEUP: prdata = {16'd0, r_makeup};
            apc_pkg::REG_DRYWET: prdata = {15'd0, r_dw};
            default: prdata = '0;
        endcase
    end

    apc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .o_in_ready(o_ready),
        .o_out_valid(o_valid), .i_out_ready(i_ready),
        .i_buffer_start(i_buffer_start), .i_stat(stat), .o_cmd(cmd)
    );

    apc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_sample(i_sample_in), .i_thr(r_thr), .i_ratio(r_ratio),
        .i_atk(r_atk), .i_rel(r_rel), .i_makeup(r_makeup), .i_dw(r_dw),
        .o_sample(o_sample_out)
    );
endmodule

[tb/sv/tb_audio_peak_compressor.sv]
// self-checking testbench for the audio peak compressor
`timescale 1ns / 1ps

module tb_audio_peak_compressor;

    localparam int SW = apc_pkg::SW;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] REG_SPARE0 = 3'd6;
    localparam logic [2:0] REG_SPARE1 = 3'd7;

    localparam logic [31:0] EXP2_STEP [12] = '{
        32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280435,
        32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
        32'd1075196443, 32'd1074468887, 32'd1074105294, 32'd1073923544
    };

    typedef struct packed {
        logic signed [SW-1:0] smp;
        logic                 bstart;
    } t_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [4:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [SW-1:0] i_sample_in = '0;
    logic                 i_buffer_start = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [SW-1:0] o_sample_out;

    audio_peak_compressor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_sample_in(i_sample_in),
        .i_buffer_start(i_buffer_start), .o_valid(o_valid), .i_ready(i_ready),
        .o_sample_out(o_sample_out)
    );

    // register copies
    logic [13:0] cfg_thr = 14'(-3072);
    logic [12:0] cfg_ratio = 13'd1024;
    logic [15:0] cfg_atk = 16'd65387;
    logic [15:0] cfg_rel = 16'd65521;
    logic [15:0] cfg_makeup = 16'd8173;
    logic [16:0] cfg_drywet = 17'd65536;

    // compressor state copies
    logic [SW-1:0]        env_lvl = '0;
    logic [31:0]          gain_s = 32'h8000_0000;
    logic signed [23:0]   thr_s = '0;
    logic [23:0]          ratio_s = 24'd65536;

    t_beat                pend_q[$];
    logic [SW-1:0]        out_q[$];
    int                   n_errors = 0;
    int                   n_sent = 0;
    int                   n_checked = 0;
    int                   cycles = 0;
    int                   burst_left = 0;
    int                   gap_left = 0;
    int                   gap_max = 0;
    int                   stall_pct = 0;
    int                   hold_left = 0;
    int                   hold_tok = 0;
    int                   hold_seen = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint rnd(longint v, int s);
        longint unsigned mag;
        longint r;
        mag = v < 0 ? longint'(-v) : v;
        r = longint'((mag + (64'd1 << (s - 1))) >> s);
        return v < 0 ? -r : r;
    endfunction

    function automatic longint log2_q16(longint unsigned e);
        int p;
        longint unsigned m;
        longint unsigned frac;
        p = 0;
        frac = 0;
        while (p < 63 && (e >> (p + 1)) != 0) p++;
        m = (p <= 30) ? e << (30 - p) : e >> (p - 30);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(p) - (SW - 1)) * 65536 + longint'(frac);
    endfunction

    function automatic logic [31:0] gain_target(logic [SW-1:0] env);
        longint envdb, thr, over;
        longint unsigned r, slope, red, e, n, f, g, m;
        if (env == 0) return 32'h8000_0000;
        envdb = rnd(log2_q16(env) * 394566, 16);
        thr = longint'(thr_s);
        if (envdb <= thr) return 32'h8000_0000;
        r = ratio_s;
        // ratio at or below one never compresses
        if (r <= 65536) return 32'h8000_0000;
        slope = ((r - 65536) << 16) / r;
        over = envdb - thr;
        red = (longint'(over) * slope + (64'd1 << 23)) >> 24;
        e = (red * 174165 + 32768) >> 16;
        n = e >> 12;
        f = e & 4095;
        if (n >= 32) return 32'd0;
        if (f == 0) return 32'((64'd1 << 31) >> n);
        g = 4096 - f;
        m = 64'd1 << 30;
        for (int i = 0; i < 12; i++)
            if (g[11 - i]) m = (m * EXP2_STEP[i] + (64'd1 << 29)) >> 30;
        return 32'(m >> n);
    endfunction

    function automatic logic [SW-1:0] compress_sample(t_beat b);
        longint st, x, wet, mix;
        longint unsigned ax, c, env, dw;
        logic [31:0] g;
        if (b.bstart) begin
            st = longint'(thr_s);
            st += rnd((longint'($signed(cfg_thr)) * 256 - st) * 1049, 20);
            thr_s = st[23:0];
            st = longint'(ratio_s);
            st += rnd((longint'(cfg_ratio) * 256 - st) * 1049, 20);
            ratio_s = st[23:0];
        end
        x = longint'(b.smp);
        ax = x < 0 ? -x : x;
        env = env_lvl;
        c = ax > env ? cfg_atk : cfg_rel;
        env = (c * env + (65536 - c) * ax + 32768) >> 16;
        env_lvl = env[SW-1:0];
        g = gain_target(env_lvl);
        st = longint'(gain_s);
        st += rnd((longint'(g) - st) * 105, 20);
        gain_s = st[31:0];
        wet = rnd(x * longint'(gain_s), 31);
        wet = rnd(wet * longint'(cfg_makeup), 12);
        dw = cfg_drywet > 65536 ? 65536 : cfg_drywet;
        mix = rnd(x * longint'(65536 - dw) + wet * longint'(dw), 16);
        if (mix > (64'sd1 << (SW - 1)) - 1) mix = (64'sd1 << (SW - 1)) - 1;
        if (mix < -(64'sd1 << (SW - 1))) mix = -(64'sd1 << (SW - 1));
        return mix[SW-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [SW-1:0] got, logic [SW-1:0] want);
        n_errors++;
        $display("mismatch %s at cycle %0d: got %0d expected %0d", what, cycles,
                 $signed(got), $signed(want));
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            apc_pkg::REG_THR:    cfg_thr = val[13:0];
            apc_pkg::REG_RATIO:  cfg_ratio = val[12:0];
            apc_pkg::REG_ATK:    cfg_atk = val[15:0];
            apc_pkg::REG_REL:    cfg_rel = val[15:0];
            apc_pkg::REG_MAKEUP: cfg_makeup = val[15:0];
            apc_pkg::REG_DRYWET: cfg_drywet = val[16:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int thr, int ratio, int atk, int rel, int mk, int dw);
        reg_write(apc_pkg::REG_THR, 32'(thr));
        reg_write(apc_pkg::REG_RATIO, 32'(ratio));
        reg_write(apc_pkg::REG_ATK, 32'(atk));
        reg_write(apc_pkg::REG_REL, 32'(rel));
        reg_write(apc_pkg::REG_MAKEUP, 32'(mk));
        reg_write(apc_pkg::REG_DRYWET, 32'(dw));
    endtask

    task automatic wait_idle();
        wait (pend_q.size() == 0 && out_q.size() == 0 && !i_valid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        logic signed [SW-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = SW'($urandom);
            2: v = SW'(8388607 - $urandom_range(0, 200000));
            3: v = SW'(-8388608 + $urandom_range(0, 200000));
            4: v = SW'($signed($urandom_range(0, 4000)) - 2000);
            default: v = $urandom_range(0, 1) ? SW'(8388607) : SW'(-8388608);
        endcase
        return v;
    endfunction

    task automatic queue_random(int count, int bs_pct);
        t_beat b;
        for (int i = 0; i < count; i++) begin
            b.smp = rand_sample();
            b.bstart = $urandom_range(0, 99) < bs_pct;
            pend_q.push_back(b);
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                out_q.push_back(compress_sample('{i_sample_in, i_buffer_start}));
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    i_sample_in <= pend_q[0].smp;
                    i_buffer_start <= pend_q[0].bstart;
                    void'(pend_q.pop_front());
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = gap_max > 0 ? $urandom_range(0, gap_max) : 0;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when a test requests one
    always @(posedge i_clk) begin
        if (hold_tok != hold_seen) begin
            hold_seen = hold_tok;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (out_q.size() == 0) begin
                report_mismatch("unexpected beat", o_sample_out, '0);
            end else begin
                if (o_sample_out !== out_q[0])
                    report_mismatch("sample_out", o_sample_out, out_q[0]);
                void'(out_q.pop_front());
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("audio_peak_compressor regression: fail");
            $finish;
        end
    end

    initial begin
        t_beat b;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // directed: extremes, silence, glide steps, sign changes
        gap_max = 0;
        stall_pct = 0;
        foreach (EXP2_STEP[k]) begin
            case (k % 6)
                0: b.smp = SW'(8388607);
                1: b.smp = SW'(-8388608);
                2: b.smp = '0;
                3: b.smp = SW'(-1);
                4: b.smp = SW'(1);
                default: b.smp = SW'(24'h555555);
            endcase
            b.bstart = k[0];
            pend_q.push_back(b);
        end
        for (int k = 0; k < 8; k++) begin
            b.smp = k[0] ? SW'(24'hAAAAAA) : SW'(8388607 - k);
            b.bstart = 1'b1;
            pend_q.push_back(b);
        end
        wait_idle();

        // hardest compression, fastest attack, dry only
        write_all(-7680, 5120, 0, 65535, 65535, 0);
        reg_write(REG_SPARE0, 32'hFFFF_FFFF);
        reg_write(REG_SPARE1, 32'h1234_5678);
        gap_max = 6;
        stall_pct = 30;
        queue_random(110, 80);
        wait_idle();

        // no compression, slow attack, dry/wet above one
        write_all(0, 256, 65535, 0, 4096, 131071);
        gap_max = 0;
        stall_pct = 0;
        queue_random(90, 60);
        wait_idle();

        // ratio below one with a low threshold
        write_all(-7680, 0, 32768, 60000, 20000, 40000);
        gap_max = 10;
        stall_pct = 70;
        queue_random(90, 60);
        wait_idle();

        // random settings, long receiver hold-off while the sender keeps going
        write_all(-$urandom_range(2000, 7680), $urandom_range(1024, 5120),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(4096, 65535), $urandom_range(0, 65536));
        gap_max = 3;
        stall_pct = 20;
        hold_tok++;
        queue_random(130, 70);
        wait_idle();

        write_all(-$urandom_range(0, 7680), $urandom_range(256, 5120),
                  $urandom_range(60000, 65535), $urandom_range(0, 65535),
                  $urandom_range(4096, 65535), $urandom_range(0, 65536));
        gap_max = 5;
        stall_pct = 50;
        queue_random(130, 50);
        wait_idle();

        $display("sent %0d samples, checked %0d results over six register settings",
                 n_sent, n_checked);
        $display("settings covered threshold and ratio extremes, mix extremes, stalls");
        if (n_errors == 0 && out_q.size() == 0) begin
            $display("audio_peak_compressor regression: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, out_q.size());
            $display("audio_peak_compressor regression: fail");
        end
        $finish;
    end

endmodule
